[rtl/lswr_pkg.sv]
// Shared types, request and status codes for the LIFO stack with reverse.
`default_nettype none
package lswr_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WORD_W    = 32;
  localparam int CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [1:0] KIND_PUSH    = 2'd0;
  localparam logic [1:0] KIND_POP     = 2'd1;
  localparam logic [1:0] KIND_REVERSE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    logic [1:0]               status;
    logic [CAP_W-1:0]         count;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rev_stat_t;

endpackage
`default_nettype wire

[rtl/lswr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lswr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/lswr_rev_seq.sv]
// Reversal sequencer: swaps stack entries pairwise from the outside in through the RAM.
`default_nettype none
module lswr_rev_seq #(
  parameter int DEPTH = lswr_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [$clog2(DEPTH)-1:0]     last_idx,
  output lswr_pkg::rev_stat_t               stat,
  output logic                              rd_en,
  output logic      [$clog2(DEPTH)-1:0]     rd_addr,
  output logic                              wr_en,
  output logic      [$clog2(DEPTH)-1:0]     wr_addr,
  output logic      [lswr_pkg::WORD_W-1:0]  wr_data,
  input  wire logic [lswr_pkg::WORD_W-1:0]  rd_data
);
  import lswr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RLO  = 3'd1;
  localparam logic [2:0] S_RHI  = 3'd2;
  localparam logic [2:0] S_WLO  = 3'd3;
  localparam logic [2:0] S_WHI  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [WORD_W-1:0] low_word;
  logic              more;

  // another swap remains when the pointers stay apart after stepping inward
  assign more = (hi - lo) > AW'(2);

  always_comb begin
    state_next = state;
    stat.busy  = (state != S_IDLE);
    stat.done  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = lo;
    wr_en      = 1'b0;
    wr_addr    = lo;
    wr_data    = rd_data;
    case (state)
      S_IDLE: begin
        if (go) state_next = S_RLO;
      end
      S_RLO: begin
        rd_en      = 1'b1;
        state_next = S_RHI;
      end
      S_RHI: begin
        rd_en      = 1'b1;
        rd_addr    = hi;
        state_next = S_WLO;
      end
      S_WLO: begin
        wr_en      = 1'b1;
        state_next = S_WHI;
      end
      S_WHI: begin
        wr_en   = 1'b1;
        wr_addr = hi;
        wr_data = low_word;
        if (more) begin
          state_next = S_RLO;
        end else begin
          state_next = S_IDLE;
          stat.done  = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      lo <= '0;
      hi <= last_idx;
    end else if (state == S_WHI) begin
      lo <= lo + AW'(1);
      hi <= hi - AW'(1);
    end
    // hold the lower word while the upper one is fetched
    if (state == S_RHI) low_word <= rd_data;
  end

endmodule
`default_nettype wire

[rtl/lifo_stack_with_reverse_top.sv]
// Top level of the LIFO stack with in-place reverse.
`default_nettype none
// A bounded LIFO of signed 32-bit words held in a RAM with one write and one
// registered read port. Push, pop and unknown requests are taken every cycle
// while no reverse is busy, and answer with done in the cycle after the
// transfer; the receiver cannot stall. A reverse of n > 1 elements holds
// busy high while the sequencer swaps pairs from the outside in (read low,
// read high, write both) and answers as busy falls. Reverse of zero or one
// element answers in the next cycle. The store needs no clearing pass.
module lifo_stack_with_reverse_top #(
  parameter int DEPTH = lswr_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lswr_pkg::req_t              req,
  input  wire logic                        cfg_we,
  input  wire logic [lswr_pkg::CAP_W-1:0]  cfg_wdata,
  output logic                             done,
  output lswr_pkg::rsp_t                   rsp
);
  import lswr_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [LIM_W-1:0]  cap_ext;
  logic [LIM_W-1:0]  limit;
  logic              push_ok;
  logic              accept;
  logic              res_now;
  logic [1:0]        st_next;
  logic              pop_rd;
  logic              push_wr;
  logic              rev_go;
  logic [1:0]        st_q;
  logic              pop_ok_q;
  rev_stat_t         rev_stat;

  logic              seq_rd_en;
  logic [AW-1:0]     seq_rd_addr;
  logic              seq_wr_en;
  logic [AW-1:0]     seq_wr_addr;
  logic [WORD_W-1:0] seq_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic [WORD_W-1:0] ram_rd_data;

  assign busy    = rev_stat.busy;
  assign accept  = start && !busy;
  assign cap_ext = LIM_W'(capacity);
  assign limit   = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
  assign push_ok = LIM_W'(cnt) < limit;

  always_comb begin
    cnt_next = cnt;
    res_now  = 1'b0;
    st_next  = ST_DONE;
    pop_rd   = 1'b0;
    push_wr  = 1'b0;
    rev_go   = 1'b0;
    if (accept) begin
      case (req.kind)
        KIND_PUSH: begin
          res_now = 1'b1;
          if (push_ok) begin
            push_wr  = 1'b1;
            cnt_next = cnt + CNT_W'(1);
          end else begin
            st_next = ST_OVERFLOW;
          end
        end
        KIND_POP: begin
          res_now = 1'b1;
          if (cnt == '0) begin
            st_next = ST_UNDERFLOW;
          end else begin
            pop_rd   = 1'b1;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        KIND_REVERSE: begin
          if (cnt == '0) begin
            res_now = 1'b1;
            st_next = ST_UNDERFLOW;
          end else if (cnt == CNT_W'(1)) begin
            res_now = 1'b1;
          end else begin
            rev_go = 1'b1;
          end
        end
        default: res_now = 1'b1;
      endcase
    end
    if (rev_stat.done) res_now = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      cnt      <= '0;
      done     <= 1'b0;
      st_q     <= ST_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      cnt      <= cnt_next;
      done     <= res_now;
      st_q     <= st_next;
      pop_ok_q <= pop_rd;
    end
  end

  // pop and push own the RAM ports only while the sequencer is idle
  assign ram_rd_en   = pop_rd || seq_rd_en;
  assign ram_rd_addr = pop_rd ? AW'(cnt - CNT_W'(1)) : seq_rd_addr;
  assign ram_wr_en   = push_wr || seq_wr_en;
  assign ram_wr_addr = push_wr ? AW'(cnt) : seq_wr_addr;
  assign ram_wr_data = push_wr ? req.value : seq_wr_data;

  lswr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lswr_rev_seq #(
    .DEPTH(DEPTH)
  ) u_rev_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (rev_go),
    .last_idx (AW'(cnt - CNT_W'(1))),
    .stat     (rev_stat),
    .rd_en    (seq_rd_en),
    .rd_addr  (seq_rd_addr),
    .wr_en    (seq_wr_en),
    .wr_addr  (seq_wr_addr),
    .wr_data  (seq_wr_data),
    .rd_data  (ram_rd_data)
  );

  assign rsp.popped = pop_ok_q ? ram_rd_data : '0;
  assign rsp.status = st_q;
  assign rsp.count  = CAP_W'(cnt);

`ifndef SYNTHESIS
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("result strobe during reversal");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(cnt) <= LIM_W'(DEPTH)) else $error("element count above depth");

  a_overflow_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_OVERFLOW |-> cnt == $past(cnt))
    else $error("overflowing push changed the count");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_UNDERFLOW |-> cnt == '0 && rsp.popped == '0)
    else $error("underflow reported on a non-empty stack");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_rd |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("pop did not decrement the count");
`endif

endmodule
`default_nettype wire

[verif/tb_lifo_stack_with_reverse_top.sv]
// Self-checking testbench for the LIFO stack with in-place reverse.
`default_nettype none
module tb_lifo_stack_with_reverse_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lswr_pkg::*;

  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // Mirrors the stack contents and predicts the answer to each request.
  class stack_scoreboard;
    logic signed [WORD_W-1:0] words [DEPTH_DEF];
    int unsigned fill;
    logic [CAP_W-1:0] capacity;
    rsp_t answers [$];
    int unsigned errors;

    function new();
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function void note_request(req_t r);
      rsp_t a;
      int unsigned lim;
      int unsigned lo;
      int unsigned hi;
      logic signed [WORD_W-1:0] t;
      a = '0;
      a.status = ST_DONE;
      lim = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
      case (r.kind)
        KIND_PUSH: begin
          if (fill >= lim) begin
            a.status = ST_OVERFLOW;
          end else begin
            words[fill] = r.value;
            fill++;
          end
        end
        KIND_POP: begin
          if (fill == 0) begin
            a.status = ST_UNDERFLOW;
          end else begin
            fill--;
            a.popped = words[fill];
          end
        end
        KIND_REVERSE: begin
          if (fill == 0) begin
            a.status = ST_UNDERFLOW;
          end else begin
            lo = 0;
            hi = fill - 1;
            while (lo < hi) begin
              t = words[lo];
              words[lo] = words[hi];
              words[hi] = t;
              lo++;
              hi--;
            end
          end
        end
        default: ;
      endcase
      a.count = CAP_W'(fill);
      answers.push_back(a);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (answers.size() == 0) begin
        $error("response with none outstanding: popped %0d status %0d count %0d",
               got.popped, got.status, got.count);
        errors++;
        return;
      end
      want = answers.pop_front();
      if (got.popped !== want.popped) begin
        $error("popped: expected %0d, got %0d", want.popped, got.popped);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic done;
  rsp_t rsp;

  stack_scoreboard sb = new();

  lifo_stack_with_reverse_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_response(rsp);
  end

  // Hold the request until the block takes it; start stays high afterwards.
  task automatic send_request(logic [1:0] kind, logic signed [WORD_W-1:0] value);
    req_t r;
    r.kind = kind;
    r.value = value;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic drain();
    while (sb.answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(cap);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random bursts of requests; weights are percentages for push and pop.
  task automatic run_phase(int n, int push_w, int pop_w);
    int left;
    int burst;
    int r;
    logic [1:0] kind;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? left : $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        r = $urandom_range(0, 99);
        if (r < push_w) kind = KIND_PUSH;
        else if (r < push_w + pop_w) kind = KIND_POP;
        else if (r < 97) kind = KIND_REVERSE;
        else kind = KIND_UNKNOWN;
        send_request(kind, pick_word());
        left--;
      end
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty stack, single element, extreme words, unknown request.
    send_request(KIND_POP, 32'sd5);
    send_request(KIND_REVERSE, 32'sd0);
    send_request(KIND_UNKNOWN, WORD_MAX);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_REVERSE, 32'sd0);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PUSH, 32'sd0);
    send_request(KIND_PUSH, -32'sd1);
    send_request(KIND_PUSH, 32'sd1);
    send_request(KIND_REVERSE, 32'sd0);
    send_request(KIND_UNKNOWN, '0);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_REVERSE, 32'sd0);

    // Capacity dropped below the fill: pushes overflow until pops catch up.
    write_capacity(CAP_W'(2));
    send_request(KIND_PUSH, 32'sd77);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_PUSH, 32'sd78);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_PUSH, 32'sd79);

    // Zero capacity refuses every push.
    write_capacity(CAP_W'(0));
    send_request(KIND_PUSH, 32'sd80);
    send_request(KIND_POP, 32'sd0);
    send_request(KIND_PUSH, 32'sd81);

    // Saturating capacity: fill to the full depth and overflow.
    write_capacity('1);
    run_phase(140, 82, 10);
    write_capacity(CAP_W'(64));
    run_phase(80, 12, 80);
    write_capacity(CAP_W'(1));
    run_phase(50, 45, 40);
    write_capacity(CAP_W'(3));
    run_phase(50, 45, 40);
    write_capacity(CAP_W'($urandom_range(1, 16)));
    run_phase(60, 50, 35);
    write_capacity(CAP_W'(0));
    run_phase(40, 40, 45);
    write_capacity(CAP_W'($urandom_range(0, 127)));
    run_phase(80, 48, 38);
    write_capacity(CAP_W'(64));
    run_phase(100, 70, 20);

    start <= 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
